@@ rtl/gbr_pkg.sv @@
// Shared types and constants for the glyph bitmap rasterizer.
`timescale 1ns / 1ps

package gbr_pkg;

    localparam int CFG_BITS      = 13;  // widest configuration register
    localparam int CFG_IDX_BITS  = 2;
    localparam int GH_BITS       = 7;   // glyph_height register
    localparam int GW_BITS       = 6;   // glyph_width field
    localparam int HT_BITS       = 8;   // holds any effective height up to 128
    localparam int BYTE_BITS_PIX = 8;   // pixels carried by one bitmap byte

    localparam logic [CFG_BITS-1:0] SCREEN_WIDTH_RST  = 13'd320;
    localparam logic [CFG_BITS-1:0] SCREEN_HEIGHT_RST = 13'd240;
    localparam logic [GH_BITS-1:0]  GLYPH_HEIGHT_RST  = 7'd16;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_SCREEN_WIDTH  = 2'd0,
        CFG_SCREEN_HEIGHT = 2'd1,
        CFG_GLYPH_HEIGHT  = 2'd2
    } cfg_idx_e;

    typedef struct packed {
        logic [CFG_BITS-1:0] screen_width;
        logic [CFG_BITS-1:0] screen_height;
        logic [GH_BITS-1:0]  glyph_height;
    } cfg_t;

    // One decoded byte: bit k stands for column k of the byte (k = 0 leftmost).
    typedef struct packed {
        logic [BYTE_BITS_PIX-1:0] emit;
        logic [BYTE_BITS_PIX-1:0] fg;
    } job_t;

endpackage

@@ rtl/glyph_bitmap_rasterizer.sv @@
// Top level of the glyph bitmap rasterizer: stream ports, configuration registers, two stages.
`timescale 1ns / 1ps

// Each slave transaction carries one bitmap byte of a glyph (rows MSB first,
// ceil(width/8) bytes per row). The byte is decoded in the same cycle it is
// taken into a pixel mask, which is held in the emitter; the emitter sends one
// pixel per cycle into the master output register while that register is free
// (not stalled by m_tready), left to right, with tlast on the last pixel of the
// byte. A byte yields up to eight pixels, and the next byte is taken in the
// cycle its predecessor's last pixel moves to the output register, so a
// stream of full bytes runs with no gaps on the master side. A byte that
// yields no pixel (rejected glyph, no active glyph, bits past the width,
// clear bits without background) is consumed and produces nothing. The first
// pixel of a byte goes through the mask register, then the output register.
// tuser on the slave side is glyph_start: it latches origin, width and the
// background flag and runs the screen bounds check for the whole glyph.
// Configuration writes take effect at the next edge and should be made while
// the block is idle.
module glyph_bitmap_rasterizer #(
    parameter int MAX_GLYPH_WIDTH  = 32,
    parameter int MAX_GLYPH_HEIGHT = 64,
    parameter int COORD_BITS       = 12,
    localparam int S_DATA_BITS = ((8 + 2 * COORD_BITS + 7) + 7) / 8 * 8,
    localparam int M_DATA_BITS = ((2 * COORD_BITS) + 7) / 8 * 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // glyph_byte[7:0], origin_x, origin_y, glyph_width[5:0], bg_enable, zero pad
    input  logic [S_DATA_BITS-1:0]              s_tdata,
    input  logic                                s_tuser,   // glyph_start
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // pixel_x, pixel_y, zero pad
    output logic [M_DATA_BITS-1:0]              m_tdata,
    output logic                                m_tuser,   // foreground
    output logic                                m_tlast,   // last pixel of the byte
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_wr_en,
    input  logic [gbr_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [gbr_pkg::CFG_BITS-1:0]        cfg_wdata
);
    import gbr_pkg::*;

    cfg_t                  cfg_reg, cfg_next;
    logic                  accept;
    logic                  job_load;
    job_t                  job;
    logic [COORD_BITS-1:0] job_x;
    logic [COORD_BITS-1:0] job_y;
    logic                  job_ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;

    // Configuration registers; writes beyond the list are dropped.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_SCREEN_WIDTH:  cfg_next.screen_width  = cfg_wdata;
                CFG_SCREEN_HEIGHT: cfg_next.screen_height = cfg_wdata;
                CFG_GLYPH_HEIGHT:  cfg_next.glyph_height  = cfg_wdata[GH_BITS-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.screen_width  <= SCREEN_WIDTH_RST;
            cfg_reg.screen_height <= SCREEN_HEIGHT_RST;
            cfg_reg.glyph_height  <= GLYPH_HEIGHT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // A byte is taken whenever the emitter can hold its pixel mask.
    assign s_tready = job_ready;
    assign accept   = s_tvalid && s_tready;

    gbr_decode #(
        .MAX_GLYPH_WIDTH  (MAX_GLYPH_WIDTH),
        .MAX_GLYPH_HEIGHT (MAX_GLYPH_HEIGHT),
        .COORD_BITS       (COORD_BITS)
    ) u_decode (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .glyph_byte  (s_tdata[7:0]),
        .glyph_start (s_tuser),
        .origin_x    (s_tdata[8 +: COORD_BITS]),
        .origin_y    (s_tdata[8 + COORD_BITS +: COORD_BITS]),
        .glyph_width (s_tdata[8 + 2 * COORD_BITS +: GW_BITS]),
        .bg_enable   (s_tdata[8 + 2 * COORD_BITS + GW_BITS]),
        .cfg         (cfg_reg),
        .job_load    (job_load),
        .job         (job),
        .job_x       (job_x),
        .job_y       (job_y)
    );

    gbr_emit #(
        .COORD_BITS (COORD_BITS)
    ) u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .job_load   (job_load),
        .job        (job),
        .job_x      (job_x),
        .job_y      (job_y),
        .job_ready  (job_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .foreground (m_tuser),
        .last       (m_tlast)
    );

    assign m_tdata = M_DATA_BITS'({pixel_y, pixel_x});

endmodule

@@ rtl/gbr_decode.sv @@
// Glyph walker: latches glyph geometry, runs the bounds check, and turns a byte into a pixel mask.
`timescale 1ns / 1ps

module gbr_decode #(
    parameter int MAX_GLYPH_WIDTH  = 32,
    parameter int MAX_GLYPH_HEIGHT = 64,
    parameter int COORD_BITS       = 12
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        accept,
    input  logic [7:0]                  glyph_byte,
    input  logic                        glyph_start,
    input  logic [COORD_BITS-1:0]       origin_x,
    input  logic [COORD_BITS-1:0]       origin_y,
    input  logic [gbr_pkg::GW_BITS-1:0] glyph_width,
    input  logic                        bg_enable,
    input  gbr_pkg::cfg_t               cfg,
    output logic                        job_load,
    output gbr_pkg::job_t               job,
    output logic [COORD_BITS-1:0]       job_x,
    output logic [COORD_BITS-1:0]       job_y
);
    import gbr_pkg::*;

    localparam int BPR_MAX   = (MAX_GLYPH_WIDTH + 7) / 8;
    localparam int BYTE_BITS = (BPR_MAX > 1) ? $clog2(BPR_MAX) : 1;
    localparam int ROW_BITS  = $clog2(MAX_GLYPH_HEIGHT + 1);
    localparam int CHK_BITS  = ((COORD_BITS > CFG_BITS) ? COORD_BITS : CFG_BITS) + 2;
    localparam int COL_BITS  = BYTE_BITS + 3;

    logic [ROW_BITS-1:0]   row_reg,   row_next;
    logic [BYTE_BITS-1:0]  byte_reg,  byte_next;
    logic                  active_reg, active_next;
    logic [COORD_BITS-1:0] lx_reg,    lx_next;
    logic [COORD_BITS-1:0] ly_reg,    ly_next;
    logic [GW_BITS-1:0]    lw_reg,    lw_next;
    logic                  lbg_reg,   lbg_next;

    logic [HT_BITS-1:0]    h_eff;
    logic                  start_ok;
    logic                  act;
    logic                  live;
    logic [ROW_BITS-1:0]   row_cur;
    logic [BYTE_BITS-1:0]  byte_cur;
    logic [HT_BITS-1:0]    row_inc;
    logic [3:0]            byte_inc;
    logic [3:0]            bpr;
    logic [COL_BITS-1:0]   col;

    // Height register clamped to the supported maximum.
    always_comb begin
        if (HT_BITS'(cfg.glyph_height) > HT_BITS'(MAX_GLYPH_HEIGHT)) begin
            h_eff = HT_BITS'(MAX_GLYPH_HEIGHT);
        end else begin
            h_eff = HT_BITS'(cfg.glyph_height);
        end
    end

    assign start_ok = (glyph_width != '0)
                   && (HT_BITS'(glyph_width) <= HT_BITS'(MAX_GLYPH_WIDTH))
                   && (h_eff != '0)
                   && (CHK_BITS'(origin_x) + CHK_BITS'(glyph_width) + CHK_BITS'(1)
                       < CHK_BITS'(cfg.screen_width))
                   && (CHK_BITS'(origin_y) + CHK_BITS'(h_eff) + CHK_BITS'(1)
                       < CHK_BITS'(cfg.screen_height));

    // Geometry seen by this byte: fresh on a start byte, latched otherwise.
    assign lx_next  = glyph_start ? origin_x    : lx_reg;
    assign ly_next  = glyph_start ? origin_y    : ly_reg;
    assign lw_next  = glyph_start ? glyph_width : lw_reg;
    assign lbg_next = glyph_start ? bg_enable   : lbg_reg;
    assign act      = glyph_start ? start_ok    : active_reg;
    assign row_cur  = glyph_start ? '0          : row_reg;
    assign byte_cur = glyph_start ? '0          : byte_reg;

    assign live     = act && (HT_BITS'(row_cur) < h_eff);
    assign row_inc  = HT_BITS'(row_cur) + HT_BITS'(1);
    assign byte_inc = 4'(byte_cur) + 4'd1;
    assign bpr      = 4'((7'(lw_next) + 7'd7) >> 3);

    always_comb begin
        job.emit = '0;
        job.fg   = '0;
        col      = '0;
        for (int k = 0; k < BYTE_BITS_PIX; k++) begin
            col         = {byte_cur, 3'(k)};
            job.fg[k]   = glyph_byte[BYTE_BITS_PIX-1-k];
            job.emit[k] = live && (7'(col) < 7'(lw_next))
                       && (glyph_byte[BYTE_BITS_PIX-1-k] || lbg_next);
        end
    end

    assign job_x    = lx_next + COORD_BITS'({byte_cur, 3'b000});
    assign job_y    = ly_next + COORD_BITS'(row_cur);
    assign job_load = accept && (job.emit != '0);

    always_comb begin
        row_next    = row_cur;
        byte_next   = byte_cur;
        active_next = act;
        if (act && !live) begin
            // height shrank under a running glyph
            active_next = 1'b0;
        end else if (live) begin
            if (byte_inc >= bpr) begin
                byte_next   = '0;
                row_next    = ROW_BITS'(row_inc);
                active_next = (row_inc < h_eff);
            end else begin
                byte_next = BYTE_BITS'(byte_inc);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg    <= '0;
            byte_reg   <= '0;
            active_reg <= 1'b0;
            lx_reg     <= '0;
            ly_reg     <= '0;
            lw_reg     <= '0;
            lbg_reg    <= 1'b0;
        end else if (accept) begin
            row_reg    <= row_next;
            byte_reg   <= byte_next;
            active_reg <= active_next;
            lx_reg     <= lx_next;
            ly_reg     <= ly_next;
            lw_reg     <= lw_next;
            lbg_reg    <= lbg_next;
        end
    end

endmodule

@@ rtl/gbr_emit.sv @@
// Pixel emitter: holds one decoded byte, sends pixels left to right, one per unstalled cycle.
`timescale 1ns / 1ps

module gbr_emit #(
    parameter int COORD_BITS = 12
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  job_load,
    input  gbr_pkg::job_t         job,
    input  logic [COORD_BITS-1:0] job_x,
    input  logic [COORD_BITS-1:0] job_y,
    output logic                  job_ready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [COORD_BITS-1:0] pixel_x,
    output logic [COORD_BITS-1:0] pixel_y,
    output logic                  foreground,
    output logic                  last
);
    import gbr_pkg::*;

    logic                      jv_reg,   jv_next;
    logic [BYTE_BITS_PIX-1:0]  mask_reg, mask_next;
    logic [BYTE_BITS_PIX-1:0]  fg_reg,   fg_next;
    logic [COORD_BITS-1:0]     jx_reg,   jx_next;
    logic [COORD_BITS-1:0]     jy_reg,   jy_next;

    logic                      ov_reg,   ov_next;
    logic [COORD_BITS-1:0]     px_reg,   px_next;
    logic [COORD_BITS-1:0]     py_reg,   py_next;
    logic                      pfg_reg,  pfg_next;
    logic                      plast_reg, plast_next;

    logic                      out_free;
    logic                      pop;
    logic [2:0]                sel;
    logic [BYTE_BITS_PIX-1:0]  rem;

    // leftmost remaining column
    always_comb begin
        sel = '0;
        for (int k = BYTE_BITS_PIX - 1; k >= 0; k--) begin
            if (mask_reg[k]) begin
                sel = 3'(k);
            end
        end
    end

    assign out_free  = !ov_reg || m_tready;
    assign pop       = jv_reg && out_free;
    assign rem       = mask_reg & ~(BYTE_BITS_PIX'(1) << sel);
    assign job_ready = !jv_reg || (pop && (rem == '0));

    always_comb begin
        jv_next   = jv_reg;
        mask_next = mask_reg;
        fg_next   = fg_reg;
        jx_next   = jx_reg;
        jy_next   = jy_reg;
        if (job_load) begin
            jv_next   = 1'b1;
            mask_next = job.emit;
            fg_next   = job.fg;
            jx_next   = job_x;
            jy_next   = job_y;
        end else if (pop) begin
            mask_next = rem;
            jv_next   = (rem != '0);
        end
    end

    always_comb begin
        ov_next    = ov_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        pfg_next   = pfg_reg;
        plast_next = plast_reg;
        if (pop) begin
            ov_next    = 1'b1;
            px_next    = jx_reg + COORD_BITS'(sel);
            py_next    = jy_reg;
            pfg_next   = fg_reg[sel];
            plast_next = (rem == '0);
        end else if (m_tready) begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            jv_reg   <= 1'b0;
            mask_reg <= '0;
            ov_reg   <= 1'b0;
        end else begin
            jv_reg   <= jv_next;
            mask_reg <= mask_next;
            ov_reg   <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        fg_reg    <= fg_next;
        jx_reg    <= jx_next;
        jy_reg    <= jy_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
        pfg_reg   <= pfg_next;
        plast_reg <= plast_next;
    end

    assign m_tvalid   = ov_reg;
    assign pixel_x    = px_reg;
    assign pixel_y    = py_reg;
    assign foreground = pfg_reg;
    assign last       = plast_reg;

endmodule

@@ rtl/gbr_checker.sv @@
// Port-level checks for the glyph bitmap rasterizer, bound to the top level.
`timescale 1ns / 1ps

module gbr_checker #(
    parameter int COORD_BITS = 12,
    localparam int M_DATA_BITS = ((2 * COORD_BITS) + 7) / 8 * 8
) (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tready,
    input logic [M_DATA_BITS-1:0] m_tdata,
    input logic                   m_tuser,
    input logic                   m_tlast,
    input logic                   m_tvalid,
    input logic                   m_tready
);

    // Output register empties on reset.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid set after reset");

    // Stalled result transaction holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
                                   && $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled output changed");

    // Pixels of one byte follow without gaps and share the row.
    a_byte_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid
            && (m_tdata[2*COORD_BITS-1:COORD_BITS]
                == $past(m_tdata[2*COORD_BITS-1:COORD_BITS])))
        else $error("gap or row change inside a byte");

    // A pending byte cannot drain while the output is stalled.
    a_no_drain_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready && !s_tready) ##1 !m_tready |-> !s_tready)
        else $error("input accepted while output stalled with a byte pending");

endmodule

bind glyph_bitmap_rasterizer gbr_checker #(.COORD_BITS(COORD_BITS)) u_gbr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
